### rtl/contiguous_fit_allocator_macros.svh
// Assertion macros for the contiguous fit allocator.
// Uses the including module's clk and rst_n; empty bodies under SYNTHESIS.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFA_ASSERT_SAME(lbl, ante, cons, msg)
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/cfa_pkg.sv
// Shared types and constants for the contiguous fit allocator.
// No dependencies.
package cfa_pkg;

    localparam int MEM_UNITS_DEF  = 1024;
    localparam int OWNER_BITS_DEF = 8;

    localparam int ACTION_W = 2;
    localparam int OWNER_W  = 8;
    localparam int REQ_W    = 11;
    localparam int START_W  = 10;
    localparam int LEFT_W   = 11;

    localparam logic [ACTION_W-1:0] ACT_FIRST = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BEST  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

### rtl/cfa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module cfa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/cfa_fit_unit.sv
// Hole scoring unit: fit test, leftover and policy compare against the best so far.
// Depends on cfa_pkg.
module cfa_fit_unit
    import cfa_pkg::*;
#(
    parameter int CMP_W = 11
) (
    input  logic                close,
    input  logic [ACTION_W-1:0] policy,
    input  logic                found,
    input  logic [CMP_W-1:0]    hole_len,
    input  logic [CMP_W-1:0]    want,
    input  logic [CMP_W-1:0]    best_left,
    output logic                take,
    output logic [CMP_W-1:0]    left
);

    logic fits;

    always_comb
    begin
        fits = close && (hole_len >= want);
        left = hole_len - want;
        take = 1'b0;
        if (fits)
        begin
            if (!found)
            begin
                take = 1'b1;
            end
            else
            begin
                case (policy)
                    ACT_BEST:  take = left < best_left;
                    ACT_WORST: take = left > best_left;
                    default:   take = 1'b0;
                endcase
            end
        end
    end

endmodule

### rtl/contiguous_fit_allocator.sv
// A request with a valid policy and nonzero size scans the whole map; a grant then writes request_size units.
// One request at a time; the map scan (one unit per cycle through the RAM port) sets the rate.
// After reset a clearing pass writes every map unit free; no request is taken meanwhile.
// Depends on cfa_pkg, cfa_ram, cfa_fit_unit and contiguous_fit_allocator_macros.svh.
`include "contiguous_fit_allocator_macros.svh"
module contiguous_fit_allocator
    import cfa_pkg::*;
#(
    parameter int MEM_UNITS  = MEM_UNITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [OWNER_W-1:0]  owner_id,
    input  logic [REQ_W-1:0]    request_size,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                granted,
    output logic [START_W-1:0]  start_unit,
    output logic [LEFT_W-1:0]   leftover
);

    localparam int ADDR_W = $clog2(MEM_UNITS);
    localparam int LEN_W  = $clog2(MEM_UNITS + 1);
    localparam int CMP_W  = (LEN_W > REQ_W) ? LEN_W : REQ_W;
    localparam int MAP_W  = OWNER_BITS + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_UNITS - 1);

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [LEN_W-1:0]       run_len_reg, run_len_next;
    logic [ADDR_W-1:0]      run_start_reg, run_start_next;
    logic                   found_reg, found_next;
    logic [ADDR_W-1:0]      best_start_reg, best_start_next;
    logic [CMP_W-1:0]       best_left_reg, best_left_next;
    logic [ACTION_W-1:0]    policy_reg, policy_next;
    logic [OWNER_BITS-1:0]  owner_reg, owner_next;
    logic [REQ_W-1:0]       want_reg, want_next;
    logic [REQ_W-1:0]       cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   granted_reg, granted_next;
    logic [START_W-1:0]     start_reg, start_next;
    logic [LEFT_W-1:0]      left_reg, left_next;

    logic                   mem_we;
    logic [MAP_W-1:0]       mem_wdata;
    logic [MAP_W-1:0]       mem_rdata;
    logic                   unit_free;
    logic                   pos_last;
    logic                   hole_close;
    logic [LEN_W-1:0]       hole_len;
    logic [ADDR_W-1:0]      hole_start;
    logic                   take;
    logic [CMP_W-1:0]       hole_left;
    logic [31:0]            start_wide;
    logic [31:0]            owner_wide;

    cfa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MEM_UNITS)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .addr  (addr_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign unit_free  = !mem_rdata[MAP_W-1];
    assign pos_last   = pos_reg == LAST_ADDR;
    assign hole_close = pend_reg && (!unit_free || pos_last);
    assign hole_len   = run_len_reg + LEN_W'(unit_free);
    assign hole_start = (run_len_reg == '0) ? pos_reg : run_start_reg;

    cfa_fit_unit #(
        .CMP_W (CMP_W)
    ) u_fit (
        .close     (hole_close),
        .policy    (policy_reg),
        .found     (found_reg),
        .hole_len  (CMP_W'(hole_len)),
        .want      (CMP_W'(want_reg)),
        .best_left (best_left_reg),
        .take      (take),
        .left      (hole_left)
    );

    assign mem_we     = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign mem_wdata  = (state_reg == ST_CLEAR) ? '0 : {1'b1, owner_reg};
    assign in_stall   = state_reg != ST_IDLE;
    assign start_wide = 32'(best_start_reg);
    assign owner_wide = 32'(owner_id);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        pend_next       = 1'b0;
        pos_next        = pos_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        found_next      = found_reg;
        best_start_next = best_start_reg;
        best_left_next  = best_left_reg;
        policy_next     = policy_reg;
        owner_next      = owner_reg;
        want_next       = want_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        granted_next    = granted_reg;
        start_next      = start_reg;
        left_next       = left_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    policy_next     = action;
                    owner_next      = owner_wide[OWNER_BITS-1:0];
                    want_next       = request_size;
                    found_next      = 1'b0;
                    addr_next       = '0;
                    issue_done_next = 1'b0;
                    run_len_next    = '0;
                    if ((action != ACT_FIRST && action != ACT_BEST && action != ACT_WORST)
                        || request_size == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    pend_next       = 1'b1;
                    pos_next        = addr_reg;
                    addr_next       = addr_reg + 1'b1;
                    issue_done_next = addr_reg == LAST_ADDR;
                end
                if (pend_reg)
                begin
                    if (hole_close)
                    begin
                        run_len_next = '0;
                    end
                    else
                    begin
                        run_len_next   = hole_len;
                        run_start_next = hole_start;
                    end
                    if (take)
                    begin
                        found_next      = 1'b1;
                        best_start_next = hole_start;
                        best_left_next  = hole_left;
                    end
                    if (pos_last)
                    begin
                        addr_next  = take ? hole_start : best_start_reg;
                        cnt_next   = want_reg;
                        state_next = (take || found_reg) ? ST_WRITE : ST_DONE;
                    end
                end
            end
            ST_WRITE:
            begin
                addr_next = addr_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == REQ_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = found_reg;
                    start_next     = found_reg ? start_wide[START_W-1:0] : '0;
                    left_next      = found_reg ? best_left_reg[LEFT_W-1:0] : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            issue_done_reg <= 1'b1;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        best_start_reg <= best_start_next;
        best_left_reg  <= best_left_next;
        policy_reg     <= policy_next;
        owner_reg      <= owner_next;
        want_reg       <= want_next;
        cnt_reg        <= cnt_next;
        granted_reg    <= granted_next;
        start_reg      <= start_next;
        left_reg       <= left_next;
    end

    assign out_valid  = out_valid_reg;
    assign granted    = granted_reg;
    assign start_unit = start_reg;
    assign leftover   = left_reg;

    `CFA_ASSERT_SAME(a_nogrant_zero, out_valid_reg && !granted_reg, start_reg == '0 && left_reg == '0, "refused beat carries nonzero fields")
    `CFA_ASSERT_SAME(a_write_found, state_reg == ST_WRITE, found_reg && cnt_reg != '0, "write phase without a chosen hole")
    `CFA_ASSERT_SAME(a_write_in_map, state_reg == ST_WRITE, addr_reg <= LAST_ADDR, "write past end of map")
    `CFA_ASSERT_SAME(a_result_from_done, out_valid_reg && !$past(out_valid_reg), $past(state_reg) == ST_DONE, "result beat not from done state")
    `CFA_ASSERT_NEXT(a_scan_issue_once, state_reg == ST_SCAN && issue_done_reg, issue_done_reg || state_reg != ST_SCAN, "scan read issue restarted")

endmodule

### dv/contiguous_fit_allocator_tb.sv
// Testbench for contiguous_fit_allocator: first, best and worst fit requests are
// checked against a predictor that keeps its own copy of the owner map.
// Depends on cfa_pkg and the allocator RTL.
module contiguous_fit_allocator_tb
    import cfa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam int                  UNITS       = MEM_UNITS_DEF;

    typedef struct packed {
        logic               granted;
        logic [START_W-1:0] start_u;
        logic [LEFT_W-1:0]  left_u;
    } grant_t;

    class allocation_board;
        bit                 unit_taken[UNITS];
        logic [OWNER_W-1:0] unit_owner[UNITS];
        grant_t             expected_grants[$];
        int                 errors;
        int                 checked;
        int                 grants;
        int                 units_used;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_grants.size();
        endfunction

        function int largest_hole();
            int run;
            int best;
            run  = 0;
            best = 0;
            for (int u = 0; u < UNITS; u++) begin
                run = unit_taken[u] ? 0 : run + 1;
                if (run > best)
                    best = run;
            end
            return best;
        endfunction

        // scan maximal free runs, pick per policy, ties to the lowest address
        function void note_request(logic [ACTION_W-1:0] act, logic [OWNER_W-1:0] own,
                                   logic [REQ_W-1:0] sz);
            grant_t res;
            bit     found;
            int     pos;
            int     len;
            int     left;
            int     best_pos;
            int     best_left;
            res       = '0;
            found     = 1'b0;
            pos       = 0;
            best_pos  = 0;
            best_left = 0;
            if ((act != ACT_FIRST && act != ACT_BEST && act != ACT_WORST) || sz == '0) begin
                expected_grants.push_back(res);
                return;
            end
            while (pos < UNITS) begin
                if (unit_taken[pos]) begin
                    pos++;
                end
                else begin
                    len = 0;
                    while (pos + len < UNITS && !unit_taken[pos + len])
                        len++;
                    if (len >= int'(sz)) begin
                        left = len - int'(sz);
                        if (!found || (act == ACT_BEST && left < best_left)
                                   || (act == ACT_WORST && left > best_left)) begin
                            found     = 1'b1;
                            best_pos  = pos;
                            best_left = left;
                        end
                        if (act == ACT_FIRST)
                            pos = UNITS;
                    end
                    pos += len;
                end
            end
            if (found) begin
                for (int k = 0; k < int'(sz); k++) begin
                    unit_taken[best_pos + k] = 1'b1;
                    unit_owner[best_pos + k] = own;
                end
                res.granted = 1'b1;
                res.start_u = best_pos[START_W-1:0];
                res.left_u  = best_left[LEFT_W-1:0];
                grants++;
                units_used += int'(sz);
            end
            expected_grants.push_back(res);
        endfunction

        task check_grant(logic g, logic [START_W-1:0] s, logic [LEFT_W-1:0] l);
            grant_t exp_g;
            if (expected_grants.size() == 0) begin
                report($sformatf("result with nothing pending: g=%0b s=%0d l=%0d", g, s, l));
                return;
            end
            exp_g = expected_grants.pop_front();
            checked++;
            if (g !== exp_g.granted)
                report($sformatf("beat %0d granted %0b, want %0b", checked, g, exp_g.granted));
            if (s !== exp_g.start_u)
                report($sformatf("beat %0d start_unit %0d, want %0d", checked, s, exp_g.start_u));
            if (l !== exp_g.left_u)
                report($sformatf("beat %0d leftover %0d, want %0d", checked, l, exp_g.left_u));
        endtask
    endclass

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action       = '0;
    logic [OWNER_W-1:0]  owner_id     = '0;
    logic [REQ_W-1:0]    request_size = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic                granted;
    logic [START_W-1:0]  start_unit;
    logic [LEFT_W-1:0]   leftover;

    bit                  calm         = 1'b0;
    int                  sent         = 0;
    allocation_board     board        = new();

    contiguous_fit_allocator dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 35);
    end

    // results first: a result at this edge belongs to an earlier request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_grant(granted, start_unit, leftover);
        if (rst_n && in_valid && !in_stall)
            board.note_request(action, owner_id, request_size);
    end

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [OWNER_W-1:0]  own,
                                input logic [REQ_W-1:0]    sz);
        while (!calm && $urandom_range(0, 99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        owner_id     <= own;
        request_size <= sz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_grants();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    initial
    begin
        int                  r;
        int                  hole;
        logic [ACTION_W-1:0] act;
        logic [REQ_W-1:0]    sz;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_request(ACT_FIRST,   8'h00, 11'd1);
        send_request(ACT_BEST,    8'hFF, 11'd2);
        send_request(ACT_WORST,   8'hA5, 11'd3);
        send_request(ACT_UNKNOWN, 8'hFF, 11'd5);
        send_request(ACT_FIRST,   8'h5A, 11'd0);
        send_request(ACT_BEST,    8'h01, 11'd0);
        send_request(ACT_WORST,   8'h80, 11'd0);
        send_request(ACT_WORST,   8'h7F, 11'd2047);
        send_request(ACT_FIRST,   8'h33, 11'd1025);
        send_request(ACT_BEST,    8'hCC, 11'd1024);
        send_request(ACT_UNKNOWN, 8'h00, 11'd2047);
        send_request(ACT_UNKNOWN, 8'h12, 11'd0);
        send_request(ACT_FIRST,   8'hF0, 11'd4);
        send_request(ACT_BEST,    8'h0F, 11'd7);
        send_request(ACT_WORST,   8'hAA, 11'd1);
        send_request(ACT_WORST,   8'h55, 11'd1022);
        drain_grants();

        for (int i = 0; i < 275; i++) begin
            calm <= (i >= 100 && i < 160);
            r   = $urandom_range(0, 99);
            act = ACTION_W'($urandom_range(0, 2));
            if (r < 75)
                sz = REQ_W'($urandom_range(1, 6));
            else if (r < 80)
                sz = REQ_W'($urandom_range(8, 24));
            else if (r < 88)
                sz = REQ_W'($urandom_range(1025, 2047));
            else if (r < 94) begin
                act = ACT_UNKNOWN;
                sz  = REQ_W'($urandom_range(0, 2047));
            end
            else
                sz = '0;
            send_request(act, OWNER_W'($urandom_range(0, 255)), sz);
        end
        calm <= 1'b0;

        // exact fit of the largest hole, then a one-unit first fit request
        drain_grants();
        hole = board.largest_hole();
        if (hole > 0)
            send_request(ACT_WORST, 8'hFF, hole[REQ_W-1:0]);
        send_request(ACT_FIRST, 8'h00, 11'd1);

        drain_grants();
        repeat (UNITS + 8) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d granted", sent, board.checked,
                 board.grants);
        $display("%0d of %0d units allocated; all policies, bad policy, zero and oversize sizes",
                 board.units_used, UNITS);
        if (board.errors == 0)
            $display("contiguous_fit_allocator_tb: clean");
        else
            $display("contiguous_fit_allocator_tb: errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("contiguous_fit_allocator_tb: errors");
        $finish;
    end

endmodule
